// File: design/spp_pkg.sv
// ----------------------------------------------------------------------------
// Sprite slot pool package
// Shared types, codes and constants of the sprite slot pool.
// ----------------------------------------------------------------------------
package spp_pkg;

  // Pool geometry.
  localparam int SLOT_COUNT  = 64;
  localparam int SLOT_W      = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int CNT_W       = $clog2(SLOT_COUNT + 1);
  localparam int MAX_RESULTS = 64;
  localparam int RES_W       = $clog2(MAX_RESULTS + 1);

  // Lifetime given to an animated spawn.
  localparam logic [15:0] ANIM_LIFE = 16'd9;

  // Function codes of an input item.
  typedef enum logic [1:0] {
    FUNC_SPAWN_ANIM  = 2'd0,
    FUNC_SPAWN_PLAIN = 2'd1,
    FUNC_TICK        = 2'd2
  } spp_func_e;

  // Kind codes of a result item.
  typedef enum logic [1:0] {
    KIND_SPAWN  = 2'd0,
    KIND_UPDATE = 2'd1,
    KIND_IDLE   = 2'd2
  } spp_kind_e;

  typedef logic [SLOT_W-1:0] slot_idx_t;
  typedef slot_idx_t [63:0] victim_tab_t;

  // Input beat.
  typedef struct packed {
    logic [1:0]         func;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic [15:0]        image;
    logic [15:0]        lifetime;
    logic [5:0]         replace_slot;
  } spp_in_t;

  // Output beat.
  typedef struct packed {
    logic [1:0]         kind;
    logic [5:0]         slot;
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic [15:0]        out_image;
    logic               expired;
    logic               last;
  } spp_out_t;

  // Classified command passed from the front to the back.
  typedef struct packed {
    logic        is_tick;
    logic        anim;
    logic [31:0] px;
    logic [31:0] py;
    logic [31:0] vx;
    logic [31:0] vy;
    logic [15:0] img;
    logic [15:0] life;
    slot_idx_t   victim;
  } spp_cmd_t;

  // Contents of one slot.
  typedef struct packed {
    logic [31:0] px;
    logic [31:0] py;
    logic [31:0] vx;
    logic [31:0] vy;
    logic [15:0] img;
    logic [15:0] age;
    logic [15:0] life;
    logic        anim;
  } spp_slot_t;

  // Victim slot for every value of the replace field, built at elaboration.
  function automatic victim_tab_t victim_tab_f();
    victim_tab_t t;
    for (int i = 0; i < 64; i++) begin
      t[i] = slot_idx_t'(i % SLOT_COUNT);
    end
    return t;
  endfunction

  localparam victim_tab_t VICTIM_TAB = victim_tab_f();

  // Low six bits of a slot index, zero extended for small pools.
  function automatic logic [5:0] slot6(slot_idx_t s);
    logic [SLOT_W+5:0] wide;
    wide = {6'd0, s};
    return wide[5:0];
  endfunction

endpackage

// File: design/spp_front.sv
// ----------------------------------------------------------------------------
// Sprite slot pool front end
// Accepts input beats, decodes the function code and queues commands.
// ----------------------------------------------------------------------------
module spp_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  spp_pkg::spp_in_t  in_data_i,
  output logic              cmd_valid_o,
  input  logic              cmd_ready_i,
  output spp_pkg::spp_cmd_t cmd_o
);
  import spp_pkg::*;

  localparam int DEPTH = 2;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W_Q = $clog2(DEPTH + 1);

  spp_cmd_t             fifo_q [DEPTH];
  logic [PTR_W-1:0]     wr_ptr_q;
  logic [PTR_W-1:0]     rd_ptr_q;
  logic [CNT_W_Q-1:0]   count_q;
  spp_cmd_t             cmd_new;
  logic                 func_ok;
  logic                 push;
  logic                 pop;

  // Decode the beat into a command; the unused function code is dropped.
  always_comb begin
    cmd_new.is_tick = 1'b0;
    cmd_new.anim    = 1'b0;
    cmd_new.px      = in_data_i.pos_x;
    cmd_new.py      = in_data_i.pos_y;
    cmd_new.vx      = in_data_i.vel_x;
    cmd_new.vy      = in_data_i.vel_y;
    cmd_new.img     = in_data_i.image;
    cmd_new.life    = in_data_i.lifetime;
    cmd_new.victim  = VICTIM_TAB[in_data_i.replace_slot];
    func_ok         = 1'b1;
    case (in_data_i.func)
      FUNC_SPAWN_ANIM: begin
        cmd_new.anim = 1'b1;
        cmd_new.life = ANIM_LIFE;
      end
      FUNC_SPAWN_PLAIN: begin
        cmd_new.anim = 1'b0;
      end
      FUNC_TICK: begin
        cmd_new.is_tick = 1'b1;
      end
      default: begin
        func_ok = 1'b0;
      end
    endcase
  end

  assign in_ready_o  = (count_q != CNT_W_Q'(DEPTH));
  assign push        = in_valid_i && in_ready_o && func_ok;
  assign cmd_valid_o = (count_q != '0);
  assign pop         = cmd_ready_i && cmd_valid_o;
  assign cmd_o       = fifo_q[rd_ptr_q];

  // Queue pointers and fill level.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= wr_ptr_q + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + PTR_W'(1);
      end
      if (push && !pop) begin
        count_q <= count_q + CNT_W_Q'(1);
      end else if (pop && !push) begin
        count_q <= count_q - CNT_W_Q'(1);
      end
    end
  end

  // Queue storage.
  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= cmd_new;
    end
  end

endmodule

// File: design/spp_back.sv
// ----------------------------------------------------------------------------
// Sprite slot pool back end
// Holds the slot memory and carries out spawn and tick commands.
// ----------------------------------------------------------------------------
module spp_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cmd_valid_i,
  output logic              cmd_ready_o,
  input  spp_pkg::spp_cmd_t cmd_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output spp_pkg::spp_out_t out_data_o
);
  import spp_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SPAWN,
    ST_TICK_RD,
    ST_TICK_EX,
    ST_EMPTY
  } state_e;

  state_e            state_q;
  spp_cmd_t          cmd_q;
  slot_idx_t         idx_q;
  slot_idx_t         sel_q;
  logic [SLOT_COUNT-1:0] active_q;
  logic [CNT_W-1:0]  cnt_q;
  logic [CNT_W-1:0]  remaining_q;
  logic [RES_W-1:0]  n_q;
  logic              out_valid_q;
  spp_out_t          out_q;
  spp_slot_t         slot_mem_q [SLOT_COUNT];
  spp_slot_t         rd_data_q;

  logic              out_free;
  logic              emit;
  logic              tick_last;
  logic              spawn_go;
  logic              tick_go;
  logic              empty_go;
  logic              out_load;
  logic              rd_en;
  logic              scan_hit;
  logic              scan_end;
  logic [15:0]       age_inc;
  logic              freed;
  spp_slot_t         upd;
  spp_slot_t         spawn_ent;
  logic              mem_we;
  slot_idx_t         mem_waddr;
  spp_slot_t         mem_wdata;
  spp_out_t          out_next;

  assign cmd_ready_o = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign out_free    = !out_valid_q || out_ready_i;

  // Tick record bookkeeping: the record cap and the final record of a tick.
  assign emit      = (n_q < RES_W'(MAX_RESULTS));
  assign tick_last = (remaining_q == CNT_W'(1)) || (n_q == RES_W'(MAX_RESULTS - 1));

  // Free slot scan.
  assign scan_hit = !active_q[idx_q];
  assign scan_end = (idx_q == SLOT_W'(SLOT_COUNT - 1));

  assign spawn_go = (state_q == ST_SPAWN) && out_free;
  assign tick_go  = (state_q == ST_TICK_EX) && (out_free || !emit);
  assign empty_go = (state_q == ST_EMPTY) && out_free;
  assign out_load = spawn_go || (tick_go && emit) || empty_go;
  assign rd_en    = (state_q == ST_TICK_RD) && (remaining_q != '0) && active_q[idx_q];

  // One step of an active slot.
  always_comb begin
    age_inc  = rd_data_q.age + 16'd1;
    freed    = (age_inc == rd_data_q.life) || (age_inc == 16'd0);
    upd      = rd_data_q;
    upd.px   = rd_data_q.px + rd_data_q.vx;
    upd.py   = rd_data_q.py + rd_data_q.vy;
    upd.age  = freed ? 16'd0 : age_inc;
    if (rd_data_q.anim && (rd_data_q.age > 16'd1)) begin
      upd.img = rd_data_q.img + 16'd1;
    end
  end

  // Entry written by a spawn.
  always_comb begin
    spawn_ent.px   = cmd_q.px;
    spawn_ent.py   = cmd_q.py;
    spawn_ent.vx   = cmd_q.vx;
    spawn_ent.vy   = cmd_q.vy;
    spawn_ent.img  = cmd_q.img;
    spawn_ent.age  = 16'd1;
    spawn_ent.life = cmd_q.life;
    spawn_ent.anim = cmd_q.anim;
  end

  // Memory write port.
  assign mem_we    = spawn_go || tick_go;
  assign mem_waddr = spawn_go ? sel_q : idx_q;
  assign mem_wdata = spawn_go ? spawn_ent : upd;

  // Next output beat.
  always_comb begin
    out_next.kind      = KIND_IDLE;
    out_next.slot      = 6'd0;
    out_next.out_x     = '0;
    out_next.out_y     = '0;
    out_next.out_image = '0;
    out_next.expired   = 1'b0;
    out_next.last      = 1'b1;
    if (spawn_go) begin
      out_next.kind      = KIND_SPAWN;
      out_next.slot      = slot6(sel_q);
      out_next.out_x     = cmd_q.px;
      out_next.out_y     = cmd_q.py;
      out_next.out_image = cmd_q.img;
    end else if (tick_go) begin
      out_next.kind      = KIND_UPDATE;
      out_next.slot      = slot6(idx_q);
      out_next.out_x     = upd.px;
      out_next.out_y     = upd.py;
      out_next.out_image = upd.img;
      out_next.expired   = freed;
      out_next.last      = tick_last;
    end
  end

  // Sequencer, slot activity and output handshake.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      idx_q       <= '0;
      active_q    <= '0;
      cnt_q       <= '0;
      remaining_q <= '0;
      n_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end
      case (state_q)
        ST_IDLE: begin
          if (cmd_valid_i) begin
            idx_q <= '0;
            n_q   <= '0;
            if (!cmd_i.is_tick) begin
              state_q <= ST_SCAN;
            end else if (cnt_q == '0) begin
              state_q <= ST_EMPTY;
            end else begin
              remaining_q <= cnt_q;
              state_q     <= ST_TICK_RD;
            end
          end
        end
        ST_SCAN: begin
          if (scan_hit || scan_end) begin
            state_q <= ST_SPAWN;
          end else begin
            idx_q <= idx_q + SLOT_W'(1);
          end
        end
        ST_SPAWN: begin
          if (spawn_go) begin
            active_q[sel_q] <= 1'b1;
            if (!active_q[sel_q]) begin
              cnt_q <= cnt_q + CNT_W'(1);
            end
            state_q <= ST_IDLE;
          end
        end
        ST_TICK_RD: begin
          if (remaining_q == '0) begin
            state_q <= ST_IDLE;
          end else if (active_q[idx_q]) begin
            state_q <= ST_TICK_EX;
          end else begin
            idx_q <= idx_q + SLOT_W'(1);
          end
        end
        ST_TICK_EX: begin
          if (tick_go) begin
            remaining_q <= remaining_q - CNT_W'(1);
            if (emit) begin
              n_q <= n_q + RES_W'(1);
            end
            if (freed) begin
              active_q[idx_q] <= 1'b0;
              cnt_q           <= cnt_q - CNT_W'(1);
            end
            idx_q   <= idx_q + SLOT_W'(1);
            state_q <= ST_TICK_RD;
          end
        end
        ST_EMPTY: begin
          if (empty_go) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (cmd_ready_o && cmd_valid_i) begin
      cmd_q <= cmd_i;
    end
    if ((state_q == ST_SCAN) && (scan_hit || scan_end)) begin
      sel_q <= scan_hit ? idx_q : cmd_q.victim;
    end
    if (out_load) begin
      out_q <= out_next;
    end
  end

  // Slot memory: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      slot_mem_q[mem_waddr] <= mem_wdata;
    end
    if (rd_en) begin
      rd_data_q <= slot_mem_q[idx_q];
    end
  end

endmodule

// File: design/sprite_slot_pool_core.sv
// ----------------------------------------------------------------------------
// Sprite slot pool core
// Pool of sprite slots with lowest-free spawn and a per-slot tick walk.
// ----------------------------------------------------------------------------
// Spawn: scans one slot per cycle for the lowest free slot, or takes the victim
// slot if none is free; the command is queued first, then the slot write and
// output beat follow. Tick: the single read port of the slot memory sets the
// pace; each active slot is read, then updated and reported, idle ones skipped.
// Reset clears every slot's active bit at once; no clearing pass is needed.
module sprite_slot_pool_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  spp_pkg::spp_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output spp_pkg::spp_out_t out_data_o
);
  import spp_pkg::*;

  logic     cmd_valid;
  logic     cmd_ready;
  spp_cmd_t cmd;

  // Front end: accept and decode beats.
  spp_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .cmd_valid_o (cmd_valid),
    .cmd_ready_i (cmd_ready),
    .cmd_o       (cmd)
  );

  // Back end: slot memory and command execution.
  spp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_ready_o (cmd_ready),
    .cmd_i       (cmd),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule
